### design/sel_pkg.sv
// Shared types and constants of the S-expression lexer.
package sel_pkg;

  localparam int NUMBER_WIDTH_DEF = 64;
  localparam int VALUE_W = 64;
  localparam int LINE_W = 32;
  localparam int RES_DEPTH = 4;

  localparam logic [7:0] LINE_BREAK_RESET = 8'd10;

  localparam logic [7:0] CH_TILDE = 8'h7E;
  localparam logic [7:0] CH_QUOTE = 8'h27;
  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_RPAREN = 8'h29;
  localparam logic [7:0] CH_BACKTICK = 8'h60;
  localparam logic [7:0] CH_DQUOTE = 8'h22;
  localparam logic [7:0] CH_AT = 8'h40;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB = 8'h09;
  localparam logic [7:0] CH_CR = 8'h0D;
  localparam logic [7:0] CH_ZERO = 8'h30;
  localparam logic [7:0] CH_NINE = 8'h39;

  localparam logic KIND_TEXT = 1'b0;
  localparam logic KIND_DONE = 1'b1;

  localparam logic [3:0] TT_IDENT = 4'd0;
  localparam logic [3:0] TT_STRING = 4'd1;
  localparam logic [3:0] TT_NUMBER = 4'd2;
  localparam logic [3:0] TT_LPAREN = 4'd3;
  localparam logic [3:0] TT_RPAREN = 4'd4;
  localparam logic [3:0] TT_QUOTE = 4'd5;
  localparam logic [3:0] TT_QUASI = 4'd6;
  localparam logic [3:0] TT_EVAL = 4'd7;
  localparam logic [3:0] TT_UNROLL = 4'd8;
  localparam logic [3:0] TT_EOF = 4'd9;

  typedef struct packed {
    logic               kind;
    logic [3:0]         token_type;
    logic [7:0]         text_char;
    logic [VALUE_W-1:0] number_value;
    logic               number_overflow;
    logic [LINE_W-1:0]  line;
    logic               last;
  } result_t;

endpackage

### design/sel_ifs.sv
// Stream interfaces of the S-expression lexer: characters, tokens, config.
interface sel_char_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_code;
  logic       end_of_input;
  modport source (output valid, char_code, end_of_input, input ready);
  modport sink (input valid, char_code, end_of_input, output ready);
endinterface

interface sel_token_if;
  logic        valid;
  logic        ready;
  logic        kind;
  logic [3:0]  token_type;
  logic [7:0]  text_char;
  logic [63:0] number_value;
  logic        number_overflow;
  logic [31:0] line;
  logic        last;
  modport source (output valid, kind, token_type, text_char, number_value,
                  number_overflow, line, last, input ready);
  modport sink (input valid, kind, token_type, text_char, number_value,
                number_overflow, line, last, output ready);
endinterface

interface sel_cfg_if;
  logic       valid;
  logic       ready;
  logic [7:0] data;
  modport source (output valid, data, input ready);
  modport sink (input valid, data, output ready);
endinterface

### design/s_expression_lexer.sv
// S-expression lexer top level: mode logic and result queue.
//
//   channel  dir  payload                                  note
//   chars    in   char_code, end_of_input                  one char per request
//   tokens   out  kind, token_type, text_char, value, ...  0..2 per char
//   cfg      in   data (line_break_char)                   always ready
//
// A character is taken in every cycle while the 4-entry result queue has
// room for two results; each request writes its 0..2 results in that cycle.
// Results leave one per cycle while the token sink is ready, so the rate is one character per cycle
// until characters making two results outrun the output side.
// Reset: start mode, accumulator and line count zero, queue empty.
module s_expression_lexer
  import sel_pkg::*;
#(
  parameter int NUMBER_WIDTH = NUMBER_WIDTH_DEF
) (
  input logic       clk,
  input logic       rst,
  sel_char_if.sink   chars,
  sel_token_if.source tokens,
  sel_cfg_if.sink    cfg
);

  localparam int PTR_W = $clog2(RES_DEPTH);
  localparam int CNT_W = $clog2(RES_DEPTH + 1);
  localparam int NW = NUMBER_WIDTH;

  typedef enum logic [4:0] {
    M_START  = 5'b00001,
    M_IDENT  = 5'b00010,
    M_STRING = 5'b00100,
    M_NUMBER = 5'b01000,
    M_TILDE  = 5'b10000
  } mode_t;

  mode_t             mode, mode_next;
  logic [NW-1:0]     acc, acc_next;
  logic              ovf, ovf_next;
  logic [LINE_W-1:0] line_cnt, line_cnt_next;
  logic [7:0]        line_break_char;

  result_t           queue [RES_DEPTH];
  logic [PTR_W-1:0]  wr_ptr, rd_ptr;
  logic [CNT_W-1:0]  count;

  logic       take, pop;
  logic [1:0] n_res;
  result_t    r0, r1;

  logic [7:0] c;
  logic       ws, digit, ident_end;
  logic [NW-1:0]   dval;
  logic [NW+3:0]   prod;
  logic            s_emit;
  result_t         s_res;
  mode_t           s_mode;
  result_t         num_res;

  function automatic result_t make_res(logic k, logic [3:0] tt, logic [7:0] ch,
                                       logic [LINE_W-1:0] ln);
    result_t r;
    r = '0;
    r.kind = k;
    r.token_type = tt;
    r.text_char = ch;
    r.line = ln;
    return r;
  endfunction

  assign c = chars.char_code;
  assign ws = (c == CH_SPACE) || (c >= CH_TAB && c <= CH_CR);
  assign digit = (c >= CH_ZERO) && (c <= CH_NINE);
  assign ident_end = ws || c == CH_QUOTE || c == CH_LPAREN || c == CH_RPAREN ||
                     c == CH_DQUOTE;
  assign dval = NW'(c - CH_ZERO);
  assign prod = ({4'b0, acc} << 3) + ({4'b0, acc} << 1) + (NW + 4)'(dval[3:0]);

  // Handling of a character in start mode, independent of the current mode.
  always_comb begin
    s_emit = 1'b0;
    s_res = make_res(KIND_DONE, TT_IDENT, 8'd0, line_cnt);
    s_mode = M_START;
    if (ws) begin
      s_mode = M_START;
    end else if (digit) begin
      s_mode = M_NUMBER;
    end else begin
      case (c)
        CH_LPAREN: begin
          s_emit = 1'b1;
          s_res = make_res(KIND_DONE, TT_LPAREN, 8'd0, line_cnt);
        end
        CH_RPAREN: begin
          s_emit = 1'b1;
          s_res = make_res(KIND_DONE, TT_RPAREN, 8'd0, line_cnt);
        end
        CH_QUOTE: begin
          s_emit = 1'b1;
          s_res = make_res(KIND_DONE, TT_QUOTE, 8'd0, line_cnt);
        end
        CH_BACKTICK: begin
          s_emit = 1'b1;
          s_res = make_res(KIND_DONE, TT_QUASI, 8'd0, line_cnt);
        end
        CH_DQUOTE: s_mode = M_STRING;
        CH_TILDE: s_mode = M_TILDE;
        default: begin
          s_mode = M_IDENT;
          s_emit = 1'b1;
          s_res = make_res(KIND_TEXT, TT_IDENT, c, line_cnt);
        end
      endcase
    end
  end

  always_comb begin
    num_res = make_res(KIND_DONE, TT_NUMBER, 8'd0, line_cnt);
    num_res.number_value = ovf ? '0 : VALUE_W'(acc);
    num_res.number_overflow = ovf;
  end

  always_comb begin
    mode_next = mode;
    acc_next = acc;
    ovf_next = ovf;
    line_cnt_next = line_cnt;
    n_res = 2'd0;
    r0 = make_res(KIND_DONE, TT_EOF, 8'd0, line_cnt);
    r1 = make_res(KIND_DONE, TT_EOF, 8'd0, line_cnt);
    if (chars.end_of_input) begin
      n_res = 2'd2;
      case (mode)
        M_IDENT: r0 = make_res(KIND_DONE, TT_IDENT, 8'd0, line_cnt);
        M_STRING: r0 = make_res(KIND_DONE, TT_STRING, 8'd0, line_cnt);
        M_NUMBER: r0 = num_res;
        M_TILDE: r0 = make_res(KIND_DONE, TT_EVAL, 8'd0, line_cnt);
        default: n_res = 2'd1;
      endcase
      mode_next = M_START;
      acc_next = '0;
      ovf_next = 1'b0;
      line_cnt_next = '0;
    end else begin
      case (mode)
        M_IDENT: begin
          if (ident_end) begin
            r0 = make_res(KIND_DONE, TT_IDENT, 8'd0, line_cnt);
            r1 = s_res;
            n_res = s_emit ? 2'd2 : 2'd1;
            mode_next = s_mode;
          end else begin
            r0 = make_res(KIND_TEXT, TT_IDENT, c, line_cnt);
            n_res = 2'd1;
          end
        end
        M_STRING: begin
          n_res = 2'd1;
          if (c == CH_DQUOTE) begin
            r0 = make_res(KIND_DONE, TT_STRING, 8'd0, line_cnt);
            mode_next = M_START;
          end else begin
            r0 = make_res(KIND_TEXT, TT_STRING, c, line_cnt);
          end
        end
        M_NUMBER: begin
          if (digit) begin
            if (!ovf) begin
              if (prod[NW+3:NW] != 4'd0) begin
                ovf_next = 1'b1;
                acc_next = '0;
              end else begin
                acc_next = prod[NW-1:0];
              end
            end
          end else begin
            r0 = num_res;
            r1 = s_res;
            n_res = s_emit ? 2'd2 : 2'd1;
            acc_next = '0;
            ovf_next = 1'b0;
            mode_next = s_mode;
          end
        end
        M_TILDE: begin
          if (c == CH_AT) begin
            r0 = make_res(KIND_DONE, TT_UNROLL, 8'd0, line_cnt);
            n_res = 2'd1;
            mode_next = M_START;
          end else begin
            r0 = make_res(KIND_DONE, TT_EVAL, 8'd0, line_cnt);
            r1 = s_res;
            n_res = s_emit ? 2'd2 : 2'd1;
            mode_next = s_mode;
            if (digit) begin
              acc_next = dval;
              ovf_next = 1'b0;
            end
          end
        end
        default: begin
          r0 = s_res;
          n_res = s_emit ? 2'd1 : 2'd0;
          mode_next = s_mode;
          if (digit) begin
            acc_next = dval;
            ovf_next = 1'b0;
          end
        end
      endcase
      if (c == line_break_char && line_cnt != '1) begin
        line_cnt_next = line_cnt + 1'b1;
      end
    end
    r0.last = (n_res == 2'd1);
    r1.last = 1'b1;
  end

  assign chars.ready = (count <= CNT_W'(RES_DEPTH - 2));
  assign take = chars.valid && chars.ready;
  assign pop = tokens.valid && tokens.ready;
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= M_START;
      acc <= '0;
      ovf <= 1'b0;
      line_cnt <= '0;
      line_break_char <= LINE_BREAK_RESET;
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      if (cfg.valid) begin
        line_break_char <= cfg.data;
      end
      if (take) begin
        mode <= mode_next;
        acc <= acc_next;
        ovf <= ovf_next;
        line_cnt <= line_cnt_next;
        wr_ptr <= wr_ptr + PTR_W'(n_res);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      count <= count + (take ? CNT_W'(n_res) : CNT_W'(0)) - (pop ? CNT_W'(1) : CNT_W'(0));
    end
  end

  always_ff @(posedge clk) begin
    if (take && n_res != 2'd0) begin
      queue[wr_ptr] <= r0;
    end
    if (take && n_res == 2'd2) begin
      queue[wr_ptr + 1'b1] <= r1;
    end
  end

  assign tokens.valid = (count != '0);
  assign tokens.kind = queue[rd_ptr].kind;
  assign tokens.token_type = queue[rd_ptr].token_type;
  assign tokens.text_char = queue[rd_ptr].text_char;
  assign tokens.number_value = queue[rd_ptr].number_value;
  assign tokens.number_overflow = queue[rd_ptr].number_overflow;
  assign tokens.line = queue[rd_ptr].line;
  assign tokens.last = queue[rd_ptr].last;

endmodule

### tb/sv/tb_s_expression_lexer.sv
// Testbench of s_expression_lexer: directed and random character streams, checked by a predictor.
module tb_s_expression_lexer;
  import sel_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NUMBER_WIDTH = NUMBER_WIDTH_DEF;
  localparam int STALL_LIMIT = 2000;
  localparam int LONG_HOLD = 300;

  typedef enum logic [4:0] {
    LX_START  = 5'b00001,
    LX_IDENT  = 5'b00010,
    LX_STRING = 5'b00100,
    LX_NUMBER = 5'b01000,
    LX_TILDE  = 5'b10000
  } lex_state_t;

  typedef struct packed {
    logic [7:0] code;
    logic       eoi;
  } char_req_t;

  logic clk = 1'b0;
  logic rst;

  sel_char_if chars_if();
  sel_token_if tokens_if();
  sel_cfg_if cfg_if();

  s_expression_lexer #(.NUMBER_WIDTH(NUMBER_WIDTH)) DUT (
    .clk(clk),
    .rst(rst),
    .chars(chars_if),
    .tokens(tokens_if),
    .cfg(cfg_if)
  );

  always #5 clk = ~clk;

  // predictor state
  lex_state_t  lex_state = LX_START;
  logic [63:0] digit_acc = '0;
  logic        digit_ovf = 1'b0;
  logic [31:0] line_count = '0;
  logic [7:0]  line_break = LINE_BREAK_RESET;
  int          step_results;

  char_req_t char_backlog[$];
  result_t   expected_tokens[$];
  char_req_t next_req;
  int        items_queued = 0;
  int        mismatch_count = 0;
  int        send_gap_pct = 24;
  int        recv_gap_pct = 84;
  logic      hold_arm = 1'b0;
  logic      hold_done = 1'b0;
  int        hold_left = 0;
  int        stall_cycles = 0;

  function automatic bit is_space(logic [7:0] c);
    return c == CH_SPACE || (c >= CH_TAB && c <= CH_CR);
  endfunction

  function automatic bit is_digit(logic [7:0] c);
    return c >= CH_ZERO && c <= CH_NINE;
  endfunction

  function automatic bit ends_ident(logic [7:0] c);
    return is_space(c) || c == CH_QUOTE || c == CH_LPAREN || c == CH_RPAREN || c == CH_DQUOTE;
  endfunction

  function automatic logic [63:0] number_max();
    if (NUMBER_WIDTH >= 64) return '1;
    return (64'd1 << NUMBER_WIDTH) - 64'd1;
  endfunction

  task automatic add_result(input logic kind, input logic [3:0] tt, input logic [7:0] ch,
                            input logic [63:0] val, input logic ovf);
    result_t r;
    r.kind = kind;
    r.token_type = tt;
    r.text_char = ch;
    r.number_value = val;
    r.number_overflow = ovf;
    r.line = line_count;
    r.last = 1'b0;
    expected_tokens.push_back(r);
    step_results++;
  endtask

  task automatic add_done(input logic [3:0] tt);
    add_result(KIND_DONE, tt, 8'd0, 64'd0, 1'b0);
  endtask

  task automatic finish_number();
    add_result(KIND_DONE, TT_NUMBER, 8'd0, digit_ovf ? 64'd0 : digit_acc, digit_ovf);
    digit_acc = '0;
    digit_ovf = 1'b0;
  endtask

  task automatic add_digit(input logic [7:0] c);
    logic [63:0] d;
    d = 64'(c - CH_ZERO);
    if (digit_ovf) return;
    if (digit_acc > (number_max() - d) / 64'd10) begin
      digit_ovf = 1'b1;
      digit_acc = '0;
    end else begin
      digit_acc = digit_acc * 64'd10 + d;
    end
  endtask

  task automatic start_token(input logic [7:0] c);
    lex_state = LX_START;
    if (is_space(c)) return;
    if (is_digit(c)) begin
      lex_state = LX_NUMBER;
      digit_acc = 64'(c - CH_ZERO);
      digit_ovf = 1'b0;
      return;
    end
    case (c)
      CH_LPAREN: add_done(TT_LPAREN);
      CH_RPAREN: add_done(TT_RPAREN);
      CH_QUOTE: add_done(TT_QUOTE);
      CH_BACKTICK: add_done(TT_QUASI);
      CH_DQUOTE: lex_state = LX_STRING;
      CH_TILDE: lex_state = LX_TILDE;
      default: begin
        lex_state = LX_IDENT;
        add_result(KIND_TEXT, TT_IDENT, c, 64'd0, 1'b0);
      end
    endcase
  endtask

  // expected results of one accepted request
  task automatic lex_char(input logic [7:0] c, input logic eoi);
    step_results = 0;
    if (eoi) begin
      case (lex_state)
        LX_IDENT: add_done(TT_IDENT);
        LX_STRING: add_done(TT_STRING);
        LX_NUMBER: finish_number();
        LX_TILDE: add_done(TT_EVAL);
        default: ;
      endcase
      add_done(TT_EOF);
      lex_state = LX_START;
      digit_acc = '0;
      digit_ovf = 1'b0;
      line_count = '0;
    end else begin
      case (lex_state)
        LX_IDENT: begin
          if (ends_ident(c)) begin
            add_done(TT_IDENT);
            start_token(c);
          end else begin
            add_result(KIND_TEXT, TT_IDENT, c, 64'd0, 1'b0);
          end
        end
        LX_STRING: begin
          if (c == CH_DQUOTE) begin
            add_done(TT_STRING);
            lex_state = LX_START;
          end else begin
            add_result(KIND_TEXT, TT_STRING, c, 64'd0, 1'b0);
          end
        end
        LX_NUMBER: begin
          if (is_digit(c)) begin
            add_digit(c);
          end else begin
            finish_number();
            start_token(c);
          end
        end
        LX_TILDE: begin
          if (c == CH_AT) begin
            add_done(TT_UNROLL);
            lex_state = LX_START;
          end else begin
            add_done(TT_EVAL);
            start_token(c);
          end
        end
        default: start_token(c);
      endcase
      if (c == line_break && line_count != '1) line_count++;
    end
    if (step_results != 0) expected_tokens[expected_tokens.size() - 1].last = 1'b1;
  endtask

  task automatic compare_field(input string name, input logic [63:0] want,
                               input logic [63:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatch_count++;
    end
  endtask

  task automatic check_token();
    result_t want;
    if (expected_tokens.size() == 0) begin
      $error("token with nothing expected: kind %0d type %0d", tokens_if.kind,
             tokens_if.token_type);
      mismatch_count++;
      return;
    end
    want = expected_tokens.pop_front();
    compare_field("kind", 64'(want.kind), 64'(tokens_if.kind));
    compare_field("token_type", 64'(want.token_type), 64'(tokens_if.token_type));
    compare_field("text_char", 64'(want.text_char), 64'(tokens_if.text_char));
    compare_field("number_value", want.number_value, tokens_if.number_value);
    compare_field("number_overflow", 64'(want.number_overflow), 64'(tokens_if.number_overflow));
    compare_field("line", 64'(want.line), 64'(tokens_if.line));
    compare_field("last", 64'(want.last), 64'(tokens_if.last));
  endtask

  // driver: character requests
  always @(posedge clk) begin
    if (rst) begin
      chars_if.valid <= 1'b0;
    end else begin
      if (chars_if.valid && chars_if.ready) lex_char(chars_if.char_code, chars_if.end_of_input);
      if (!chars_if.valid || chars_if.ready) begin
        if (char_backlog.size() != 0 && $urandom_range(99) >= send_gap_pct) begin
          next_req = char_backlog.pop_front();
          chars_if.valid <= 1'b1;
          chars_if.char_code <= next_req.code;
          chars_if.end_of_input <= next_req.eoi;
        end else begin
          chars_if.valid <= 1'b0;
        end
      end
    end
  end

  // monitor: token results
  always @(posedge clk) begin
    if (rst) begin
      tokens_if.ready <= 1'b0;
    end else begin
      if (tokens_if.valid && tokens_if.ready) check_token();
      if (hold_arm && !hold_done) begin
        hold_done <= 1'b1;
        hold_left <= LONG_HOLD;
        tokens_if.ready <= 1'b0;
      end else if (hold_left != 0) begin
        hold_left <= hold_left - 1;
        tokens_if.ready <= 1'b0;
      end else begin
        tokens_if.ready <= $urandom_range(99) >= recv_gap_pct;
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    if (rst || (chars_if.valid && chars_if.ready) || (tokens_if.valid && tokens_if.ready) ||
        (char_backlog.size() == 0 && !chars_if.valid && expected_tokens.size() == 0)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("tb_s_expression_lexer NOT OK");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  task automatic push_item(input logic [7:0] c, input logic eoi);
    char_req_t r;
    r.code = c;
    r.eoi = eoi;
    char_backlog.push_back(r);
    items_queued++;
  endtask

  task automatic push_text(input string s);
    for (int i = 0; i < s.len(); i++) push_item(s[i], 1'b0);
  endtask

  task automatic push_digits(input int n);
    for (int i = 0; i < n; i++) push_item(CH_ZERO + 8'($urandom_range(9)), 1'b0);
  endtask

  task automatic push_number();
    int pick;
    pick = $urandom_range(15);
    if (pick == 0) push_text("18446744073709551615");
    else if (pick == 1) push_text("18446744073709551616");
    else if (pick < 6) push_digits($urandom_range(22, 18));
    else push_digits($urandom_range(4, 1));
  endtask

  task automatic push_ident();
    logic [7:0] b;
    int n;
    do b = 8'($urandom_range(255));
    while (is_space(b) || is_digit(b) || b == CH_TILDE || b == CH_QUOTE || b == CH_LPAREN ||
           b == CH_RPAREN || b == CH_BACKTICK || b == CH_DQUOTE);
    push_item(b, 1'b0);
    n = $urandom_range(6);
    for (int i = 0; i < n; i++) begin
      do b = 8'($urandom_range(255));
      while (ends_ident(b));
      push_item(b, 1'b0);
    end
  endtask

  task automatic push_string();
    logic [7:0] b;
    int n;
    push_item(CH_DQUOTE, 1'b0);
    n = $urandom_range(6);
    for (int i = 0; i < n; i++) begin
      do b = 8'($urandom_range(255));
      while (b == CH_DQUOTE);
      push_item(b, 1'b0);
    end
    if ($urandom_range(9) != 0) push_item(CH_DQUOTE, 1'b0);
  endtask

  task automatic push_space();
    int pick;
    pick = $urandom_range(7);
    if (pick < 6) push_item(pick == 5 ? CH_SPACE : CH_TAB + 8'(pick), 1'b0);
    else push_item(line_break, 1'b0);
  endtask

  // mostly well-formed token streams, some noise and early end of input
  task automatic push_program(input int n);
    int goal;
    goal = items_queued + n;
    while (items_queued < goal) begin
      case ($urandom_range(19))
        0, 1, 2, 3: push_ident();
        4, 5, 6: push_number();
        7, 8: push_string();
        9: push_item(CH_LPAREN, 1'b0);
        10: push_item(CH_RPAREN, 1'b0);
        11: push_item(CH_QUOTE, 1'b0);
        12: push_item(CH_BACKTICK, 1'b0);
        13: begin
          push_item(CH_TILDE, 1'b0);
          if ($urandom_range(1)) push_item(CH_AT, 1'b0);
        end
        14, 15, 16: push_space();
        17: push_item(8'($urandom_range(255)), 1'b0);
        18: push_item(8'($urandom_range(255)), 1'b1);
        default: push_item(line_break, 1'b0);
      endcase
      if ($urandom_range(9) < 6) push_space();
    end
    push_item(8'($urandom_range(255)), 1'b1);
  endtask

  task automatic wait_idle();
    while (char_backlog.size() != 0 || chars_if.valid || expected_tokens.size() != 0)
      @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_line_break(input logic [7:0] v);
    @(posedge clk);
    cfg_if.valid <= 1'b1;
    cfg_if.data <= v;
    do @(posedge clk);
    while (!cfg_if.ready);
    cfg_if.valid <= 1'b0;
    line_break = v;
  endtask

  initial begin
    rst = 1'b1;
    chars_if.valid = 1'b0;
    chars_if.char_code = '0;
    chars_if.end_of_input = 1'b0;
    tokens_if.ready = 1'b0;
    cfg_if.valid = 1'b0;
    cfg_if.data = '0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // directed: every token kind, lone tilde, unterminated string, flush at end
    push_text("()'");
    push_item(CH_BACKTICK, 1'b0);
    push_text("~@~\t~)\" a\"x~(07a\n");
    push_item(8'h00, 1'b0);
    push_item(8'hFF, 1'b0);
    push_item(8'hFF, 1'b1);
    push_text("\"q");
    push_item(8'h00, 1'b1);
    push_text("~");
    push_item(8'h5A, 1'b1);
    push_text("5");
    push_item(8'hA5, 1'b1);
    wait_idle();

    write_line_break(LINE_BREAK_RESET);
    push_program(225);
    wait_idle();

    send_gap_pct <= 84;
    recv_gap_pct <= 24;
    write_line_break(8'hFF);
    push_program(225);
    wait_idle();

    send_gap_pct <= 0;
    recv_gap_pct <= 0;
    write_line_break(8'h00);
    push_program(225);
    hold_arm <= 1'b1;
    wait_idle();

    write_line_break(CH_LPAREN);
    push_program(225);
    wait_idle();
    repeat (8) @(posedge clk);

    if (mismatch_count == 0) $display("tb_s_expression_lexer OK");
    else $display("tb_s_expression_lexer NOT OK");
    $finish;
  end

endmodule
